### sv/upq_pkg.sv
package upq_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_MANUAL = 2'd2,
        OP_RESET  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_UNLOCK_THR = 2'd0,
        REG_REARM_THR  = 2'd1,
        REG_REQ_HITS   = 2'd2,
        REG_PULSE      = 2'd3
    } t_reg_index;

    localparam logic [15:0] UNLOCK_THR_RESET = 16'd2000;
    localparam logic [15:0] REARM_THR_RESET  = 16'd3000;
    localparam logic [7:0]  REQ_HITS_RESET   = 8'd3;
    localparam logic [15:0] PULSE_RESET      = 16'd500;
    localparam logic [7:0]  HITS_MAX         = 8'hFF;

    typedef struct packed {
        logic [15:0] unlock_thr;
        logic [15:0] rearm_thr;
        logic [7:0]  req_hits;
        logic [15:0] pulse_ticks;
    } t_cfg;

endpackage

### sv/proximity_unlock_qualifier.sv
// The core result is combinational and is registered into the output stage when its input beat is accepted.
// Throughput: one input beat per cycle while the output drains; the state update is a single compare and count step.
// A two-entry output stage keeps input accepted for one more beat while the output stalls.
// Reset is synchronous and active low: state clears and the registers return to defaults.
module proximity_unlock_qualifier #(
    parameter int DISTANCE_BITS = 16,
    parameter int TIMER_BITS    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_opcode,
    input  logic [DISTANCE_BITS-1:0] i_distance_mm,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_relay_on,
    output logic                     o_unlocked,
    output logic                     o_fired,
    output logic [7:0]               o_hit_count,
    output logic [DISTANCE_BITS-1:0] o_last_distance_mm
);
    import upq_pkg::*;

    localparam int RW = DISTANCE_BITS + 11;

    t_cfg                     w_cfg;
    logic                     w_accept;
    logic                     w_relay, w_unlocked, w_fired;
    logic [7:0]               w_hits;
    logic [DISTANCE_BITS-1:0] w_last;
    logic [RW-1:0]            w_res, w_res_out;

    upq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_accept = i_in_valid && o_in_ready;

    upq_core #(
        .DISTANCE_BITS (DISTANCE_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (w_accept),
        .i_opcode           (i_opcode),
        .i_distance_mm      (i_distance_mm),
        .i_cfg              (w_cfg),
        .o_relay_on         (w_relay),
        .o_unlocked         (w_unlocked),
        .o_fired            (w_fired),
        .o_hit_count        (w_hits),
        .o_last_distance_mm (w_last)
    );

    assign w_res = {w_relay, w_unlocked, w_fired, w_hits, w_last};

    upq_out_buf #(
        .WIDTH (RW)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_res_out)
    );

    assign o_relay_on         = w_res_out[RW-1];
    assign o_unlocked         = w_res_out[RW-2];
    assign o_fired            = w_res_out[RW-3];
    assign o_hit_count        = w_res_out[DISTANCE_BITS+7:DISTANCE_BITS];
    assign o_last_distance_mm = w_res_out[DISTANCE_BITS-1:0];

endmodule

### sv/upq_cfg_regs.sv
module upq_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output upq_pkg::t_cfg  o_cfg
);
    import upq_pkg::*;

    t_cfg       r_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign w_index = t_reg_index'(paddr[3:2]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unlock_thr  <= UNLOCK_THR_RESET;
            r_cfg.rearm_thr   <= REARM_THR_RESET;
            r_cfg.req_hits    <= REQ_HITS_RESET;
            r_cfg.pulse_ticks <= PULSE_RESET;
        end else if (w_write) begin
            unique case (w_index)
                REG_UNLOCK_THR: r_cfg.unlock_thr  <= pwdata[15:0];
                REG_REARM_THR:  r_cfg.rearm_thr   <= pwdata[15:0];
                REG_REQ_HITS:   r_cfg.req_hits    <= pwdata[7:0];
                REG_PULSE:      r_cfg.pulse_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            REG_UNLOCK_THR: prdata = {16'd0, r_cfg.unlock_thr};
            REG_REARM_THR:  prdata = {16'd0, r_cfg.rearm_thr};
            REG_REQ_HITS:   prdata = {24'd0, r_cfg.req_hits};
            REG_PULSE:      prdata = {16'd0, r_cfg.pulse_ticks};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

### sv/upq_core.sv
module upq_core #(
    parameter int DISTANCE_BITS = 16,
    parameter int TIMER_BITS    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [1:0]               i_opcode,
    input  logic [DISTANCE_BITS-1:0] i_distance_mm,
    input  upq_pkg::t_cfg            i_cfg,
    output logic                     o_relay_on,
    output logic                     o_unlocked,
    output logic                     o_fired,
    output logic [7:0]               o_hit_count,
    output logic [DISTANCE_BITS-1:0] o_last_distance_mm
);
    import upq_pkg::*;

    localparam int CW = (DISTANCE_BITS > 16) ? DISTANCE_BITS : 16;

    logic [7:0]               r_close_hits, n_close_hits;
    logic                     r_latch, n_latch;
    logic                     r_relay, n_relay;
    logic [TIMER_BITS-1:0]    r_remaining, n_remaining;
    logic [DISTANCE_BITS-1:0] r_recent, n_recent;

    logic [CW-1:0] w_dist;
    logic [7:0]    w_hits_inc;
    logic          w_fired;

    assign w_dist     = CW'(i_distance_mm);
    assign w_hits_inc = (r_close_hits == HITS_MAX) ? HITS_MAX : r_close_hits + 8'd1;

    always_comb begin
        n_close_hits = r_close_hits;
        n_latch      = r_latch;
        n_relay      = r_relay;
        n_remaining  = r_remaining;
        n_recent     = r_recent;
        w_fired      = 1'b0;
        unique case (t_opcode'(i_opcode))
            OP_SAMPLE: begin
                n_recent = i_distance_mm;
                if (w_dist > CW'(i_cfg.rearm_thr)) begin
                    n_latch      = 1'b0;
                    n_close_hits = 8'd0;
                end else if (!r_latch) begin
                    if (w_dist <= CW'(i_cfg.unlock_thr)) begin
                        if (w_hits_inc >= i_cfg.req_hits) begin
                            n_relay      = 1'b1;
                            n_remaining  = TIMER_BITS'(i_cfg.pulse_ticks);
                            w_fired      = 1'b1;
                            n_latch      = 1'b1;
                            n_close_hits = 8'd0;
                        end else begin
                            n_close_hits = w_hits_inc;
                        end
                    end else begin
                        n_close_hits = 8'd0;
                    end
                end
            end
            OP_TICK: begin
                if (r_relay) begin
                    if (r_remaining <= TIMER_BITS'(1)) begin
                        n_remaining = '0;
                        n_relay     = 1'b0;
                    end else begin
                        n_remaining = r_remaining - TIMER_BITS'(1);
                    end
                end
            end
            OP_MANUAL: begin
                n_relay     = 1'b1;
                n_remaining = TIMER_BITS'(i_cfg.pulse_ticks);
                w_fired     = 1'b1;
                n_latch     = 1'b1;
            end
            OP_RESET: begin
                n_close_hits = 8'd0;
                n_latch      = 1'b0;
                n_recent     = '0;
                n_relay      = 1'b0;
                n_remaining  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_hits <= 8'd0;
            r_latch      <= 1'b0;
            r_relay      <= 1'b0;
            r_remaining  <= '0;
            r_recent     <= '0;
        end else if (i_accept) begin
            r_close_hits <= n_close_hits;
            r_latch      <= n_latch;
            r_relay      <= n_relay;
            r_remaining  <= n_remaining;
            r_recent     <= n_recent;
        end
    end

    assign o_relay_on         = n_relay;
    assign o_unlocked         = n_latch;
    assign o_fired            = w_fired;
    assign o_hit_count        = n_close_hits;
    assign o_last_distance_mm = n_recent;

endmodule

### sv/upq_out_buf.sv
module upq_out_buf #(
    parameter int WIDTH = 27
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic             r_out_valid, r_skid_valid;
    logic [WIDTH-1:0] r_out, r_skid;
    logic             w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= r_skid_valid && i_push;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out <= r_skid_valid ? r_skid : i_data;
            if (r_skid_valid) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule
